FILE: src/msbb_pkg.sv
// Shared types and constants of the MSB-first bit string builder.
// No dependencies; the formatter and the top level use it by scoped names.

package msbb_pkg;

    localparam int FIELD_W = 128;  // left-aligned bit string, first bit at the top
    localparam int NBITS_W = 7;    // longest string is a 127-bit uint store
    localparam int BYTE_W  = 8;

    localparam logic [2:0] OP_UINT     = 3'd0;
    localparam logic [2:0] OP_COINS    = 3'd1;
    localparam logic [2:0] OP_ADDR_HDR = 3'd2;
    localparam logic [2:0] OP_ADDR_NUL = 3'd3;
    localparam logic [2:0] OP_FINALIZE = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;
    localparam logic [2:0] OP_READ     = 3'd6;

    // Bit string to append, as the formatter hands it to the sequencer.
    typedef struct packed {
        logic                  is_store;
        logic [NBITS_W-1:0]    nbits;
        logic [FIELD_W-1:0]    bits;
    } field_t;

endpackage

FILE: src/msbb_buffer_ram.sv
// Byte buffer storage: one write port, one read port with registered data.
// No dependencies.

module msbb_buffer_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/msbb_field_fmt.sv
// Turns one command into a left-aligned bit string and its length.
// Depends on msbb_pkg.

module msbb_field_fmt (
    input  logic [2:0]       opcode,
    input  logic [63:0]      value,
    input  logic [6:0]       width,
    input  logic [2:0]       offset,
    output msbb_pkg::field_t fld
);

    logic [3:0]                      len;
    logic [msbb_pkg::FIELD_W-1:0]    raw;
    logic [msbb_pkg::NBITS_W-1:0]    n;
    logic                            is_store;
    logic [6:0]                      shamt;

    // Byte count of a coin amount: index of the highest nonzero byte, plus one.
    always_comb
    begin
        len = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (value[8*i +: 8] != 8'd0)
            begin
                len = 4'(i + 1);
            end
        end
    end

    always_comb
    begin
        raw      = '0;
        n        = '0;
        is_store = 1'b0;
        unique case (opcode)
            msbb_pkg::OP_UINT:
            begin
                raw      = {64'd0, value};
                n        = width;
                is_store = 1'b1;
            end
            msbb_pkg::OP_COINS:
            begin
                // place the count right above the significant bytes of the amount
                raw      = ({124'd0, len} << {len, 3'b000}) | {64'd0, value};
                n        = 7'({len, 3'b000}) + 7'd4;
                is_store = 1'b1;
            end
            msbb_pkg::OP_ADDR_HDR:
            begin
                raw      = {117'd0, 3'b100, value[7:0]};
                n        = 7'd11;
                is_store = 1'b1;
            end
            msbb_pkg::OP_ADDR_NUL:
            begin
                n        = 7'd2;
                is_store = 1'b1;
            end
            msbb_pkg::OP_FINALIZE:
            begin
                // a 1 and then 0s up to the byte boundary
                raw = {120'd0, 8'h80 >> offset};
                n   = (offset == 3'd0) ? 7'd0 : 7'(4'd8 - {1'b0, offset});
            end
            default:
            begin
                raw = '0;
            end
        endcase
    end

    // Drop bits above the string length off the top; first bit lands at the MSB.
    assign shamt        = 7'(8'd128 - {1'b0, n});
    assign fld.bits     = raw << shamt;
    assign fld.nbits    = n;
    assign fld.is_store = is_store;

endmodule

FILE: src/msb_first_bit_string_builder_core.sv
// Top level of the MSB-first bit string builder: sequencer, cursor and byte writer.
// Depends on msbb_pkg, msbb_field_fmt and msbb_buffer_ram.

// A command is taken when start is high and busy is low; one result word follows
// on done for a single cycle and cannot be held off. Clear, no-op, dropped stores
// and finalize on a byte boundary return done straight from the load state; a
// byte read passes through the read state first, for the buffer's registered
// read port. A store passes through the write state once for each buffer byte it
// touches, since the byte writer puts one byte per cycle through the single write
// port. busy drops in the cycle done is shown, so the next command may be
// accepted there. Clear takes no sweep: bytes past the cursor read as zero, and
// the first byte written after the cursor keeps only the bits already behind it.

module msb_first_bit_string_builder_core #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [63:0] value,
    input  logic [6:0]  width,
    input  logic [6:0]  byte_index,
    output logic        done,
    output logic [7:0]  read_data,
    output logic [10:0] bit_count,
    output logic        overflow
);

    localparam int CW     = $clog2(BUFFER_BYTES * 8 + 1);
    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int CNTW   = (CW > 11) ? CW : 11;
    localparam logic [CW-1:0] TOTAL_BITS = CW'(BUFFER_BYTES * 8);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   cursor_reg, cursor_next;
    logic                            done_reg, done_next;
    logic                            ovf_reg, ovf_next;
    logic [7:0]                      rd_reg, rd_next;
    logic [msbb_pkg::FIELD_W-1:0]    s_reg, s_next;
    logic [msbb_pkg::NBITS_W-1:0]    rem_reg, rem_next;
    logic [2:0]                      op_reg;
    logic [63:0]                     value_reg;
    logic [6:0]                      width_reg;
    logic [6:0]                      idx_reg;

    msbb_pkg::field_t                fld;
    logic [2:0]                      off;
    logic [CW-1:0]                   room;
    logic                            fits;
    logic [3:0]                      span;
    logic [3:0]                      k;
    logic [CW-1:0]                   idx_ext;
    logic [CW-1:0]                   fill;
    logic [CNTW-1:0]                 cur_ext;

    logic                            ram_we;
    logic                            ram_re;
    logic [ADDR_W-1:0]               ram_raddr;
    logic [7:0]                      ram_wdata;
    logic [7:0]                      ram_rdata;

    msbb_field_fmt u_fmt (
        .opcode (op_reg),
        .value  (value_reg),
        .width  (width_reg),
        .offset (off),
        .fld    (fld)
    );

    msbb_buffer_ram #(
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cursor_reg[ADDR_W+2:3]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign off     = cursor_reg[2:0];
    assign room    = TOTAL_BITS - cursor_reg;
    assign fits    = CW'(fld.nbits) <= room;
    assign span    = 4'd8 - {1'b0, off};
    assign k       = ({3'b000, span} < rem_reg) ? span : rem_reg[3:0];
    assign idx_ext = CW'(idx_reg);
    assign fill    = CW'(cursor_reg[CW-1:3]);

    assign ram_re    = (state_reg == ST_LOAD);
    assign ram_raddr = (op_reg == msbb_pkg::OP_READ) ? idx_ext[ADDR_W-1:0]
                                                     : cursor_reg[ADDR_W+2:3];
    assign ram_we    = (state_reg == ST_WRITE);
    // keep bits already behind the cursor, zero everything after the new bits
    assign ram_wdata = (ram_rdata & ~(8'hFF >> off)) | (s_reg[127:120] >> off);

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        done_next   = 1'b0;
        ovf_next    = ovf_reg;
        rd_next     = rd_reg;
        s_next      = s_reg;
        rem_next    = rem_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (op_reg == msbb_pkg::OP_READ)
                begin
                    state_next = ST_READ;
                end
                else if (fld.nbits != '0 && fits)
                begin
                    state_next = ST_WRITE;
                    s_next     = fld.bits;
                    rem_next   = fld.nbits;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    rd_next    = 8'd0;
                    ovf_next   = fld.is_store && !fits;
                    if (op_reg == msbb_pkg::OP_CLEAR)
                    begin
                        cursor_next = '0;
                    end
                end
            end
            ST_WRITE:
            begin
                cursor_next = cursor_reg + CW'(k);
                rem_next    = rem_reg - 7'(k);
                s_next      = s_reg << k;
                if (rem_reg == 7'(k))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    rd_next    = 8'd0;
                    ovf_next   = 1'b0;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                ovf_next   = 1'b0;
                if (idx_ext < fill)
                begin
                    rd_next = ram_rdata;
                end
                else if (idx_ext == fill && off != 3'd0)
                begin
                    // partly filled byte: hide stale bits past the cursor
                    rd_next = ram_rdata & ~(8'hFF >> off);
                end
                else
                begin
                    rd_next = 8'd0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            rd_reg     <= 8'd0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            done_reg   <= done_next;
            ovf_reg    <= ovf_next;
            rd_reg     <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        rem_reg <= rem_next;
        if (state_reg == ST_IDLE && start)
        begin
            op_reg    <= opcode;
            value_reg <= value;
            width_reg <= width;
            idx_reg   <= byte_index;
        end
    end

    assign cur_ext   = CNTW'(cursor_reg);
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign read_data = rd_reg;
    assign bit_count = cur_ext[10:0];
    assign overflow  = ovf_reg;

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= TOTAL_BITS)
        else $error("bit cursor past end of buffer");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != ST_IDLE)
        else $error("result word without a command in flight");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (cursor_reg < TOTAL_BITS && rem_reg != '0))
        else $error("byte write outside buffer or with nothing left");

    a_drop_holds_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && ovf_reg) |-> cursor_reg == $past(cursor_reg))
        else $error("dropped store moved the cursor");

endmodule

FILE: dv/msbb_status_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the MSB-first bit string builder: mirrors the byte buffer and bit cursor,
// predicts the status word of every accepted command and compares it when done fires.
// Depends on msbb_pkg for the opcode constants.

module msbb_status_checker #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  opcode,
    input  logic [63:0] value,
    input  logic [6:0]  width,
    input  logic [6:0]  byte_index,
    input  logic        done,
    input  logic [7:0]  read_data,
    input  logic [10:0] bit_count,
    input  logic        overflow,
    output int          mismatches,
    output int          words_pending
);

    localparam int TOTAL_BITS  = BUFFER_BYTES * 8;
    localparam int PRINT_LIMIT = 200;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [10:0] bit_count;
        logic        overflow;
    } status_word_t;

    logic [7:0]   shadow_bytes [BUFFER_BYTES];
    int unsigned  shadow_cursor;
    status_word_t status_fifo [$];

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Overwrite the bit under the cursor; bits past the buffer are lost.
    function automatic void append_bit(input logic b);
        int unsigned idx;
        idx = shadow_cursor >> 3;
        if (idx < BUFFER_BYTES)
            shadow_bytes[idx][7 - (shadow_cursor % 8)] = b;
        shadow_cursor++;
    endfunction

    // Low n bits of v, MSB first; positions above bit 63 read as zero.
    function automatic void append_field(input logic [63:0] v, input int unsigned n);
        int unsigned pos;
        for (int unsigned i = 0; i < n; i++)
        begin
            pos = n - 1 - i;
            append_bit(pos < 64 ? v[pos] : 1'b0);
        end
    endfunction

    function automatic bit room_for(input int unsigned n);
        return shadow_cursor <= TOTAL_BITS && n <= TOTAL_BITS - shadow_cursor;
    endfunction

    function automatic status_word_t apply_command(input logic [2:0] op, input logic [63:0] val,
                                                   input logic [6:0] w, input logic [6:0] idx);
        status_word_t s;
        int           nbytes;
        s = '0;
        case (op)
            msbb_pkg::OP_UINT:
                if (room_for(w))
                    append_field(val, w);
                else
                    s.overflow = 1'b1;
            msbb_pkg::OP_COINS:
            begin
                nbytes = 0;
                while (nbytes < 8 && (val >> (8 * nbytes)) != 64'd0)
                    nbytes++;
                if (room_for(4 + 8 * nbytes))
                begin
                    append_field(64'(nbytes), 4);
                    for (int k = nbytes - 1; k >= 0; k--)
                        append_field((val >> (8 * k)) & 64'hFF, 8);
                end
                else
                    s.overflow = 1'b1;
            end
            msbb_pkg::OP_ADDR_HDR:
                if (room_for(11))
                    append_field({53'd0, 3'b100, val[7:0]}, 11);
                else
                    s.overflow = 1'b1;
            msbb_pkg::OP_ADDR_NUL:
                if (room_for(2))
                    append_field(64'd0, 2);
                else
                    s.overflow = 1'b1;
            msbb_pkg::OP_FINALIZE:
                if (shadow_cursor % 8 != 0 && shadow_cursor < TOTAL_BITS)
                begin
                    append_bit(1'b1);
                    while (shadow_cursor % 8 != 0)
                        append_bit(1'b0);
                end
            msbb_pkg::OP_CLEAR:
            begin
                foreach (shadow_bytes[i])
                    shadow_bytes[i] = '0;
                shadow_cursor = 0;
            end
            msbb_pkg::OP_READ:
                if (idx < BUFFER_BYTES)
                    s.read_data = shadow_bytes[idx];
            default: ;
        endcase
        s.bit_count = 11'(shadow_cursor);
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        status_word_t want;
        if (!rst_n)
        begin
            foreach (shadow_bytes[i])
                shadow_bytes[i] = '0;
            shadow_cursor = 0;
            status_fifo.delete();
            words_pending <= 0;
        end
        else
        begin
            // Retire first: a new command may be taken in the cycle done is shown.
            if (done)
            begin
                if (status_fifo.size() == 0)
                    report_mismatch($sformatf("status word with nothing pending: rd=%02h cnt=%0d ovf=%b",
                                              read_data, bit_count, overflow));
                else
                begin
                    want = status_fifo.pop_front();
                    if (read_data !== want.read_data)
                        report_mismatch($sformatf("read_data %02h, want %02h",
                                                  read_data, want.read_data));
                    if (bit_count !== want.bit_count)
                        report_mismatch($sformatf("bit_count %0d, want %0d",
                                                  bit_count, want.bit_count));
                    if (overflow !== want.overflow)
                        report_mismatch($sformatf("overflow %b, want %b",
                                                  overflow, want.overflow));
                end
            end
            if (start && !busy)
                status_fifo.push_back(apply_command(opcode, value, width, byte_index));
            words_pending <= status_fifo.size();
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Top of the bit string builder testbench: clock, reset, command stimulus and verdict.
// Depends on msbb_pkg, msb_first_bit_string_builder_core and msbb_status_checker.

module tb;

    localparam int         BUFFER_BYTES  = 128;
    localparam int         RANDOM_WORDS  = 1900;
    localparam int         CYCLE_LIMIT   = 400_000;
    localparam int         DRAIN_EVERY   = 300;
    localparam int         SETTLE_CYCLES = 25;
    localparam int         MAX_GAP       = 12;
    localparam logic [2:0] OP_NONE       = 3'd7;  // unused opcode

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  opcode;
    logic [63:0] value;
    logic [6:0]  width;
    logic [6:0]  byte_index;
    logic        done;
    logic [7:0]  read_data;
    logic [10:0] bit_count;
    logic        overflow;

    int mismatches;
    int words_pending;
    int words_sent;
    int idle_pct;
    int cycles;
    int first_random;
    int next_drain;

    msb_first_bit_string_builder_core #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .value      (value),
        .width      (width),
        .byte_index (byte_index),
        .done       (done),
        .read_data  (read_data),
        .bit_count  (bit_count),
        .overflow   (overflow)
    );

    msbb_status_checker #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) status_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .value         (value),
        .width         (width),
        .byte_index    (byte_index),
        .done          (done),
        .read_data     (read_data),
        .bit_count     (bit_count),
        .overflow      (overflow),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("msb_first_bit_string_builder_core test failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [6:0] rand_width();
        if ($urandom_range(99) < 85)
            return 7'($urandom_range(0, 64));
        return 7'($urandom_range(65, 127));
    endfunction

    // Spread the byte count of coin amounts evenly over 0..8.
    function automatic logic [63:0] coin_amount();
        return rand64() >> (8 * $urandom_range(0, 8));
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [63:0] val,
                             input logic [6:0] w, input logic [6:0] idx);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        value      <= val;
        width      <= w;
        byte_index <= idx;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    // Hold off until every status word in flight has come back.
    task automatic drain_pending();
        start <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    // A well-formed run of fields, optionally after a clear and optionally padded, followed by up to three reads.
    task automatic send_message();
        int fields;
        int pick;
        fields = $urandom_range(1, 6);
        if ($urandom_range(7) == 0)
            send_word(msbb_pkg::OP_CLEAR, rand64(), 7'($urandom), 7'($urandom));
        repeat (fields)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_word(msbb_pkg::OP_UINT, rand64(), rand_width(), 7'($urandom));
            else if (pick < 70)
                send_word(msbb_pkg::OP_COINS, coin_amount(), 7'($urandom), 7'($urandom));
            else if (pick < 85)
            begin
                send_word(msbb_pkg::OP_ADDR_HDR, rand64(), 7'($urandom), 7'($urandom));
                repeat (4) send_word(msbb_pkg::OP_UINT, rand64(), 7'd64, 7'($urandom));
            end
            else
                send_word(msbb_pkg::OP_ADDR_NUL, rand64(), 7'($urandom), 7'($urandom));
        end
        if ($urandom_range(1) == 1)
            send_word(msbb_pkg::OP_FINALIZE, rand64(), 7'($urandom), 7'($urandom));
        repeat ($urandom_range(0, 3))
            send_word(msbb_pkg::OP_READ, rand64(), 7'($urandom),
                      $urandom_range(1) == 1 ? 7'($urandom_range(0, 47)) : 7'($urandom));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = msbb_pkg::OP_UINT;
        value      = '0;
        width      = '0;
        byte_index = '0;
        words_sent = 0;
        idle_pct   = 22;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(msbb_pkg::OP_UINT, '1, 7'd0, 7'd0);
        send_word(msbb_pkg::OP_UINT, '1, 7'd64, 7'd0);
        send_word(msbb_pkg::OP_UINT, '1, 7'd127, 7'd0);    // top 63 bits come out as zeros
        send_word(msbb_pkg::OP_COINS, 64'd0, 7'd0, 7'd0);
        send_word(msbb_pkg::OP_COINS, 64'h80, 7'd0, 7'd0);
        send_word(msbb_pkg::OP_COINS, 64'h100, 7'd0, 7'd0);
        send_word(msbb_pkg::OP_COINS, '1, 7'd0, 7'd0);
        send_word(msbb_pkg::OP_ADDR_HDR, '1, 7'd0, 7'd0);
        send_word(msbb_pkg::OP_ADDR_NUL, 64'd0, 7'd0, 7'd0);
        send_word(msbb_pkg::OP_FINALIZE, 64'd0, 7'd0, 7'd0);  // cursor off a byte boundary
        send_word(msbb_pkg::OP_FINALIZE, 64'd0, 7'd0, 7'd0);  // already aligned
        send_word(msbb_pkg::OP_READ, 64'd0, 7'd0, 7'd0);
        send_word(OP_NONE, '1, '1, '1);
        send_word(msbb_pkg::OP_CLEAR, 64'd0, 7'd0, 7'd0);
        // Fill to 1016 bits, then push stores past the end.
        repeat (8) send_word(msbb_pkg::OP_UINT, rand64(), 7'd127, 7'd0);
        send_word(msbb_pkg::OP_COINS, '1, 7'd0, 7'd0);
        send_word(msbb_pkg::OP_ADDR_HDR, 64'h5A, 7'd0, 7'd0);
        send_word(msbb_pkg::OP_UINT, rand64(), 7'd8, 7'd0);
        send_word(msbb_pkg::OP_FINALIZE, 64'd0, 7'd0, 7'd0);  // full buffer
        send_word(msbb_pkg::OP_ADDR_NUL, 64'd0, 7'd0, 7'd0);
        send_word(msbb_pkg::OP_READ, 64'd0, 7'd0, 7'd127);
        drain_pending();

        first_random = words_sent;
        next_drain   = words_sent + DRAIN_EVERY;
        while (words_sent - first_random < RANDOM_WORDS)
        begin
            if (words_sent - first_random < RANDOM_WORDS / 3)
                idle_pct = 22;
            else if (words_sent - first_random < 2 * RANDOM_WORDS / 3)
                idle_pct = 63;
            else
                idle_pct = 0;
            if ($urandom_range(99) < 85)
                send_message();
            else
                send_word(3'($urandom), rand64(), 7'($urandom), 7'($urandom));
            if (words_sent >= next_drain)
            begin
                drain_pending();
                next_drain += DRAIN_EVERY;
            end
        end

        drain_pending();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && words_pending == 0)
            $display("msb_first_bit_string_builder_core test passed");
        else
            $display("msb_first_bit_string_builder_core test failed");
        $finish;
    end

endmodule
